// ===== src/clsp_pkg.sv =====
// clsp_pkg: shared types, codes and constants of the clip launch segment planner
// no dependencies
`timescale 1ns / 1ps

package clsp_pkg;

    localparam int POSITION_BITS = 48;
    localparam int LOOP_BITS     = 32;
    localparam int BAR_BITS      = 24;
    localparam int FRAME_BITS    = 13;
    localparam int SLOTS         = 4;

    localparam logic [FRAME_BITS-1:0] MAX_BLOCK   = 13'd4096;
    localparam logic [BAR_BITS-1:0]   BAR_RESET   = 24'd88200;
    localparam logic signed [3:0]     SCENE_NONE  = -4'sd1;

    typedef enum logic [1:0] {
        ACT_PLAY    = 2'd0,
        ACT_SILENCE = 2'd1,
        ACT_STATUS  = 2'd2
    } action_t;

    typedef enum logic {
        OP_QUEUE = 1'b0,
        OP_BLOCK = 1'b1
    } op_t;

    // one result item waiting in the output buffer
    typedef struct packed {
        logic [FRAME_BITS-1:0] offset;
        logic [FRAME_BITS-1:0] length;
        logic [LOOP_BITS-1:0]  cpos;
        logic signed [3:0]     scene;
        action_t               action;
        logic                  flush;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_bar;
        logic div_pos;
        logic eval;
        logic plan;
        logic pop;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_queue;
        logic need_bar;
        logic need_pos;
        logic div_done;
        logic last_slot;
    } stat_t;

    function automatic slot_t make_slot(logic [FRAME_BITS-1:0] off, logic [FRAME_BITS-1:0] len,
                                        logic [LOOP_BITS-1:0] cpos, logic signed [3:0] scene,
                                        action_t act, logic flush);
        slot_t s;
        s.offset = off;
        s.length = len;
        s.cpos   = cpos;
        s.scene  = scene;
        s.action = act;
        s.flush  = flush;
        return s;
    endfunction

endpackage

// ===== src/clsp_div.sv =====
// clsp_div: restoring remainder unit, one quotient bit per cycle
// depends on clsp_pkg
`timescale 1ns / 1ps

module clsp_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [clsp_pkg::POSITION_BITS-1:0]   dividend,
    input  logic [clsp_pkg::LOOP_BITS-1:0]       divisor,
    output logic                                 done,
    output logic [clsp_pkg::LOOP_BITS-1:0]       remainder
);

    localparam int CNT_BITS = $clog2(clsp_pkg::POSITION_BITS + 1);

    logic [clsp_pkg::POSITION_BITS-1:0] dvd_reg;
    logic [clsp_pkg::LOOP_BITS-1:0]     dvs_reg;
    logic [clsp_pkg::LOOP_BITS-1:0]     rem_reg, rem_next;
    logic [CNT_BITS-1:0]                cnt_reg;
    logic                               busy_reg, done_reg;
    logic [clsp_pkg::LOOP_BITS:0]       trial;

    // shift in next dividend bit and subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[clsp_pkg::POSITION_BITS-1]};
        if (trial >= {1'b0, dvs_reg})
            rem_next = clsp_pkg::LOOP_BITS'(trial - {1'b0, dvs_reg});
        else
            rem_next = trial[clsp_pkg::LOOP_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(clsp_pkg::POSITION_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[clsp_pkg::POSITION_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/clsp_datapath.sv =====
// clsp_datapath: track state, bar and loop arithmetic, result buffer
// depends on clsp_pkg and clsp_div
`timescale 1ns / 1ps

module clsp_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  clsp_pkg::cmd_t                        cmd,
    output clsp_pkg::stat_t                       stat,
    input  logic                                  cfg_we,
    input  logic [clsp_pkg::BAR_BITS-1:0]         cfg_data,
    input  logic                                  operation,
    input  logic signed [3:0]                     scene_request,
    input  logic [clsp_pkg::POSITION_BITS-1:0]    block_start,
    input  logic [clsp_pkg::FRAME_BITS-1:0]       block_frames,
    input  logic [clsp_pkg::LOOP_BITS-1:0]        active_loop_len,
    input  logic [clsp_pkg::LOOP_BITS-1:0]        pending_loop_len,
    output clsp_pkg::slot_t                       out_slot,
    output logic signed [3:0]                     active_now,
    output logic signed [3:0]                     pending_now
);

    localparam int FB = clsp_pkg::FRAME_BITS;
    localparam int LB = clsp_pkg::LOOP_BITS;
    localparam int PB = clsp_pkg::POSITION_BITS;

    // configuration and track state
    logic [clsp_pkg::BAR_BITS-1:0] bar_reg;
    logic signed [3:0]             active_reg, pend_reg;
    logic                          stop_reg;
    logic [PB-1:0]                 act_sample_reg;

    // captured item
    logic                          op_reg;
    logic [PB-1:0]                 pos_reg;
    logic [FB-1:0]                 frames_reg;
    logic [LB-1:0]                 aloop_reg, ploop_reg;

    // plan registers
    logic [FB-1:0]                 sw_reg;
    logic                          switch_reg;
    logic                          ge_reg;
    logic                          used_pos_reg;

    // result buffer
    clsp_pkg::slot_t               slot_reg [clsp_pkg::SLOTS];
    clsp_pkg::slot_t               slot_next [clsp_pkg::SLOTS];
    logic [2:0]                    count_reg, count_next;
    logic [1:0]                    rd_reg;

    // divider operands
    logic                          div_start, div_done;
    logic [PB-1:0]                 div_dividend;
    logic [LB-1:0]                 div_divisor, div_rem;
    logic                          pos_ge;

    assign pos_ge       = pos_reg >= act_sample_reg;
    assign div_start    = cmd.div_bar | cmd.div_pos;
    assign div_dividend = cmd.div_bar ? pos_reg :
                          (pos_ge ? pos_reg - act_sample_reg : act_sample_reg - pos_reg);
    assign div_divisor  = cmd.div_bar ? LB'(bar_reg) : aloop_reg;

    clsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // bar boundary check
    logic                          need_bar;
    logic [clsp_pkg::BAR_BITS-1:0] bar_gap;
    logic                          has_switch;

    assign need_bar   = (stop_reg || pend_reg != clsp_pkg::SCENE_NONE) && bar_reg != '0;
    assign bar_gap    = (div_rem == '0) ? '0 : bar_reg - div_rem[clsp_pkg::BAR_BITS-1:0];
    assign has_switch = need_bar && (bar_gap < clsp_pkg::BAR_BITS'(frames_reg));

    // segment planning
    logic [LB-1:0] p;
    logic [LB:0]   pre_end;
    logic [FB-1:0] first, post, ploop_cut;

    always_comb
    begin
        if (!used_pos_reg)
            p = '0;
        else if (ge_reg)
            p = div_rem;
        else
            p = (div_rem == '0) ? '0 : aloop_reg - div_rem;
        pre_end   = {1'b0, p} + (LB + 1)'(sw_reg);
        first     = FB'(aloop_reg - p);
        post      = frames_reg - sw_reg;
        ploop_cut = FB'(ploop_reg);
    end

    always_comb
    begin
        for (int i = 0; i < clsp_pkg::SLOTS; i++)
            slot_next[i] = slot_reg[i];
        count_next = 3'd0;
        // old scene up to the boundary
        if (active_reg != clsp_pkg::SCENE_NONE && sw_reg != '0)
        begin
            if (aloop_reg == '0)
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot('0, sw_reg, '0, active_reg,
                                                                 clsp_pkg::ACT_SILENCE, 1'b0);
                count_next = count_next + 3'd1;
            end
            else if (pre_end <= {1'b0, aloop_reg})
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot('0, sw_reg, p, active_reg,
                                                                 clsp_pkg::ACT_PLAY, 1'b0);
                count_next = count_next + 3'd1;
            end
            else
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot('0, first, p, active_reg,
                                                                 clsp_pkg::ACT_PLAY, 1'b0);
                count_next = count_next + 3'd1;
                slot_next[count_next[1:0]] = clsp_pkg::make_slot(first, sw_reg - first, '0,
                                                                 active_reg,
                                                                 clsp_pkg::ACT_PLAY, 1'b0);
                count_next = count_next + 3'd1;
            end
        end
        // after the boundary: stop, or new scene from loop start
        if (switch_reg)
        begin
            if (stop_reg)
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot(sw_reg, post, '0,
                                                                 clsp_pkg::SCENE_NONE,
                                                                 clsp_pkg::ACT_SILENCE, 1'b1);
                count_next = count_next + 3'd1;
            end
            else if (ploop_reg == '0)
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot(sw_reg, post, '0, pend_reg,
                                                                 clsp_pkg::ACT_SILENCE, 1'b1);
                count_next = count_next + 3'd1;
            end
            else if (LB'(post) <= ploop_reg)
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot(sw_reg, post, '0, pend_reg,
                                                                 clsp_pkg::ACT_PLAY, 1'b1);
                count_next = count_next + 3'd1;
            end
            else
            begin
                slot_next[count_next[1:0]] = clsp_pkg::make_slot(sw_reg, ploop_cut, '0,
                                                                 pend_reg,
                                                                 clsp_pkg::ACT_PLAY, 1'b1);
                count_next = count_next + 3'd1;
                slot_next[count_next[1:0]] = clsp_pkg::make_slot(sw_reg + ploop_cut,
                                                                 post - ploop_cut, '0,
                                                                 pend_reg,
                                                                 clsp_pkg::ACT_PLAY, 1'b0);
                count_next = count_next + 3'd1;
            end
        end
        // nothing to write: status only
        if (count_next == 3'd0)
        begin
            slot_next[0] = clsp_pkg::make_slot('0, '0, '0, clsp_pkg::SCENE_NONE,
                                               clsp_pkg::ACT_STATUS, 1'b0);
            count_next   = 3'd1;
        end
    end

    // control state: configuration, track state, buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_reg        <= clsp_pkg::BAR_RESET;
            active_reg     <= clsp_pkg::SCENE_NONE;
            pend_reg       <= clsp_pkg::SCENE_NONE;
            stop_reg       <= 1'b0;
            act_sample_reg <= '0;
            count_reg      <= 3'd0;
            rd_reg         <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                bar_reg <= cfg_data;
            if (cmd.load)
            begin
                rd_reg <= 2'd0;
                if (operation == clsp_pkg::OP_QUEUE)
                begin
                    count_reg <= 3'd1;
                    if (scene_request < 0)
                    begin
                        stop_reg <= 1'b1;
                        pend_reg <= clsp_pkg::SCENE_NONE;
                    end
                    else
                    begin
                        stop_reg <= 1'b0;
                        pend_reg <= scene_request;
                    end
                end
            end
            if (cmd.plan)
            begin
                count_reg <= count_next;
                if (switch_reg)
                begin
                    pend_reg <= clsp_pkg::SCENE_NONE;
                    stop_reg <= 1'b0;
                    if (stop_reg)
                        active_reg <= clsp_pkg::SCENE_NONE;
                    else
                    begin
                        active_reg     <= pend_reg;
                        act_sample_reg <= pos_reg + PB'(sw_reg);
                    end
                end
            end
            if (cmd.pop)
                rd_reg <= rd_reg + 2'd1;
        end
    end

    // item capture, plan values and buffer contents
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            pos_reg      <= block_start;
            frames_reg   <= (block_frames > clsp_pkg::MAX_BLOCK) ? clsp_pkg::MAX_BLOCK
                                                                 : block_frames;
            aloop_reg    <= active_loop_len;
            ploop_reg    <= pending_loop_len;
            used_pos_reg <= 1'b0;
            slot_reg[0]  <= clsp_pkg::make_slot('0, '0, '0, clsp_pkg::SCENE_NONE,
                                                clsp_pkg::ACT_STATUS, 1'b0);
        end
        if (cmd.eval)
        begin
            switch_reg <= has_switch;
            sw_reg     <= has_switch ? FB'(bar_gap) : frames_reg;
        end
        if (cmd.div_pos)
        begin
            ge_reg       <= pos_ge;
            used_pos_reg <= 1'b1;
        end
        if (cmd.plan)
        begin
            for (int i = 0; i < clsp_pkg::SLOTS; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    // status toward the controller
    assign stat.is_queue  = op_reg == clsp_pkg::OP_QUEUE;
    assign stat.need_bar  = need_bar;
    assign stat.need_pos  = active_reg != clsp_pkg::SCENE_NONE && sw_reg != '0
                            && aloop_reg != '0;
    assign stat.div_done  = div_done;
    assign stat.last_slot = {1'b0, rd_reg} == count_reg - 3'd1;

    assign out_slot    = slot_reg[rd_reg];
    assign active_now  = active_reg;
    assign pending_now = pend_reg;

endmodule

// ===== src/clsp_ctrl.sv =====
// clsp_ctrl: sequencer for item capture, divisions, planning and result drain
// depends on clsp_pkg
`timescale 1ns / 1ps

module clsp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  clsp_pkg::stat_t stat,
    output clsp_pkg::cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_START   = 8'b0000_0010,
        ST_DIV_BAR = 8'b0000_0100,
        ST_CHECK   = 8'b0000_1000,
        ST_DECIDE  = 8'b0001_0000,
        ST_DIV_POS = 8'b0010_0000,
        ST_PLAN    = 8'b0100_0000,
        ST_DRAIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.is_queue)
                    state_next = ST_DRAIN;
                else if (stat.need_bar)
                begin
                    cmd.div_bar = 1'b1;
                    state_next  = ST_DIV_BAR;
                end
                else
                    state_next = ST_CHECK;
            end
            ST_DIV_BAR:
            begin
                if (stat.div_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.need_pos)
                begin
                    cmd.div_pos = 1'b1;
                    state_next  = ST_DIV_POS;
                end
                else
                    state_next = ST_PLAN;
            end
            ST_DIV_POS:
            begin
                if (stat.div_done)
                    state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.pop = 1'b1;
                    if (stat.last_slot)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/clip_launch_segment_planner_unit.sv =====
// clip_launch_segment_planner_unit: top level of the clip launch segment planner
// depends on clsp_pkg, clsp_ctrl, clsp_datapath (which holds clsp_div)
//
// channel   direction  handshake               payload
// cfg       in         cfg_valid / cfg_ready   cfg_data = bar_length
// s         in         s_tvalid / s_tready     s_tdata, s_tuser
// m         out        m_tvalid / m_tready     m_tdata, m_tuser, m_tlast
//
// a queue item goes through capture, decode, then its one result
// a block item goes through capture, decode, up to two remainder passes in the
// shared divider (bar boundary, then clip position), check, decide, plan, then its
// results, up to four
// reset restores bar_length 88200, idle track, no pending scene
// m_tready low holds the current result; no new item is taken until all results leave
`timescale 1ns / 1ps

module clip_launch_segment_planner_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [23:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // scene_request, block_start, block_frames, active_loop_len, pending_loop_len, zero pad
    input  logic [135:0] s_tdata,
    // operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // buffer_offset, segment_length, clip_position, segment_scene, flush_notes,
    // active_now, pending_now, zero pad
    output logic [71:0]  m_tdata,
    // action
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    clsp_pkg::cmd_t   cmd;
    clsp_pkg::stat_t  stat;
    clsp_pkg::slot_t  out_slot;
    logic signed [3:0] active_now, pending_now;

    assign cfg_ready = 1'b1;

    clsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clsp_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_valid),
        .cfg_data         (cfg_data),
        .operation        (s_tuser[0]),
        .scene_request    (s_tdata[3:0]),
        .block_start      (s_tdata[51:4]),
        .block_frames     (s_tdata[64:52]),
        .active_loop_len  (s_tdata[96:65]),
        .pending_loop_len (s_tdata[128:97]),
        .out_slot         (out_slot),
        .active_now       (active_now),
        .pending_now      (pending_now)
    );

    // result packing
    assign m_tdata = {1'b0, pending_now, active_now, out_slot.flush, out_slot.scene,
                      out_slot.cpos, out_slot.length, out_slot.offset};
    assign m_tuser = out_slot.action;
    assign m_tlast = stat.last_slot;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for the clip launch segment planner, with its own planner
// model that predicts every segment item and compares the outputs field by field
// depends on clsp_pkg and clip_launch_segment_planner_unit
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT = 600000;
    localparam int SETTLE = 120;

    typedef struct {
        logic [12:0]       off;
        logic [12:0]       len;
        logic [31:0]       cpos;
        logic signed [3:0] scene;
        clsp_pkg::action_t act;
        logic              flush;
        logic signed [3:0] active_now;
        logic signed [3:0] pending_now;
        logic              last;
    } seg_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [23:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // planner model state
    logic [23:0]  bar_len;
    int           active_scene;
    int           pending_scene;
    bit           stop_queued;
    logic [47:0]  activation_pos;

    seg_t         expected_segs[$];
    seg_t         item_segs[$];
    int           errors;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_request;
    int           hold_left;
    bit           hold_off;
    longint       cycles;
    logic [47:0]  timeline;

    clip_launch_segment_planner_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    function automatic void add_seg(longint unsigned off, longint unsigned len,
                                    longint unsigned cpos, int scene,
                                    clsp_pkg::action_t act, bit flush);
        seg_t s;
        s.off = off[12:0];
        s.len = len[12:0];
        s.cpos = cpos[31:0];
        s.scene = scene[3:0];
        s.act = act;
        s.flush = flush;
        s.active_now = '0;
        s.pending_now = '0;
        s.last = 1'b0;
        item_segs.push_back(s);
    endfunction

    // one played stretch, split once at the loop seam
    function automatic void plan_play(longint unsigned off, longint unsigned len,
                                      longint unsigned start, int scene,
                                      longint unsigned loop, bit flush);
        longint unsigned p;
        longint unsigned r;
        longint unsigned first;
        if (len == 0)
            return;
        if (scene < 0 || scene >= 8 || loop == 0)
        begin
            add_seg(off, len, 0, scene, clsp_pkg::ACT_SILENCE, flush);
            return;
        end
        if (start >= activation_pos)
            p = (start - activation_pos) % loop;
        else
        begin
            r = (activation_pos - start) % loop;
            p = (r != 0) ? loop - r : 0;
        end
        if (p + len <= loop)
            add_seg(off, len, p, scene, clsp_pkg::ACT_PLAY, flush);
        else
        begin
            first = loop - p;
            add_seg(off, first, p, scene, clsp_pkg::ACT_PLAY, flush);
            add_seg(off + first, len - first, 0, scene, clsp_pkg::ACT_PLAY, 1'b0);
        end
    endfunction

    // works out the segments of one accepted item and updates the track state
    function automatic void plan_item(clsp_pkg::op_t op, logic [3:0] req, logic [47:0] start,
                                      logic [12:0] frames, logic [31:0] aloop,
                                      logic [31:0] ploop);
        longint unsigned pos;
        longint unsigned nfr;
        longint unsigned sw;
        longint unsigned bnd;
        longint unsigned bl;
        int act0;
        int pend;
        bit stop;
        bit has_sw;
        seg_t s;
        item_segs.delete();
        if (op == clsp_pkg::OP_QUEUE)
        begin
            if (req[3])
            begin
                stop_queued = 1'b1;
                pending_scene = -1;
            end
            else
            begin
                pending_scene = int'(req);
                stop_queued = 1'b0;
            end
            add_seg(0, 0, 0, -1, clsp_pkg::ACT_STATUS, 1'b0);
        end
        else
        begin
            pos = start;
            nfr = (frames > 13'd4096) ? 4096 : frames;
            bl = bar_len;
            act0 = active_scene;
            pend = pending_scene;
            stop = stop_queued;
            has_sw = 1'b0;
            sw = nfr;
            if ((stop || pend != -1) && bl != 0)
            begin
                bnd = pos + (bl - pos % bl) % bl;
                if (bnd < pos + nfr)
                begin
                    sw = bnd - pos;
                    has_sw = 1'b1;
                end
            end
            if (act0 != -1 && sw > 0)
                plan_play(0, sw, pos, act0, aloop, 1'b0);
            if (has_sw)
            begin
                pending_scene = -1;
                stop_queued = 1'b0;
                if (stop)
                begin
                    add_seg(sw, nfr - sw, 0, -1, clsp_pkg::ACT_SILENCE, 1'b1);
                    active_scene = -1;
                end
                else
                begin
                    activation_pos = 48'(pos + sw);
                    active_scene = pend;
                    plan_play(sw, nfr - sw, activation_pos, pend, ploop, 1'b1);
                end
            end
            if (item_segs.size() == 0)
                add_seg(0, 0, 0, -1, clsp_pkg::ACT_STATUS, 1'b0);
        end
        foreach (item_segs[k])
        begin
            s = item_segs[k];
            s.active_now = active_scene[3:0];
            s.pending_now = pending_scene[3:0];
            s.last = (k == item_segs.size() - 1);
            expected_segs.push_back(s);
        end
    endfunction

    // long receiver hold-off, counted in cycles
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            hold_off <= 1'b1;
        end
        else
            hold_off <= 1'b0;
    end

    // result side: random stalls, checks each accepted item
    always @(posedge clk)
    begin
        seg_t e;
        logic [12:0] a_off;
        logic [12:0] a_len;
        logic [31:0] a_cpos;
        logic [3:0]  a_scene;
        logic        a_flush;
        logic [3:0]  a_act;
        logic [3:0]  a_pend;
        if (rst_n && m_tvalid && m_tready)
        begin
            a_off = m_tdata[12:0];
            a_len = m_tdata[25:13];
            a_cpos = m_tdata[57:26];
            a_scene = m_tdata[61:58];
            a_flush = m_tdata[62];
            a_act = m_tdata[66:63];
            a_pend = m_tdata[70:67];
            if (expected_segs.size() == 0)
            begin
                $display("%0t: unexpected item off=%0d len=%0d cpos=%0d action=%0d",
                         $time, a_off, a_len, a_cpos, m_tuser);
                errors++;
            end
            else
            begin
                e = expected_segs.pop_front();
                if (a_off !== e.off || a_len !== e.len || a_cpos !== e.cpos
                    || a_scene !== e.scene || m_tuser !== e.act || a_flush !== e.flush
                    || a_act !== e.active_now || a_pend !== e.pending_now
                    || m_tlast !== e.last)
                begin
                    $display("%0t: mismatch expected off=%0d len=%0d cpos=%0d scene=%0d act=%0d flush=%0b active=%0d pending=%0d last=%0b",
                             $time, e.off, e.len, e.cpos, e.scene, e.act, e.flush,
                             e.active_now, e.pending_now, e.last);
                    $display("%0t:          actual   off=%0d len=%0d cpos=%0d scene=%0d act=%0d flush=%0b active=%0d pending=%0d last=%0b",
                             $time, a_off, a_len, a_cpos, $signed(a_scene), m_tuser, a_flush,
                             $signed(a_act), $signed(a_pend), m_tlast);
                    errors++;
                end
            end
        end
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_bar(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        bar_len = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input clsp_pkg::op_t op, input logic [3:0] req,
                             input logic [47:0] start, input logic [12:0] frames,
                             input logic [31:0] aloop, input logic [31:0] ploop);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'b0, ploop, aloop, frames, start, req};
        do
            @(posedge clk);
        while (!s_tready);
        plan_item(op, req, start, frames, aloop, ploop);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_loop();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return 32'd0;
        if (sel < 16)
            return $urandom();
        if (sel < 18)
            return 32'hFFFF_FFFF;
        return $urandom_range(1, 400);
    endfunction

    function automatic logic [12:0] rand_frames();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)
            return 13'd0;
        if (sel < 6)
            return 13'd4096;
        if (sel < 9)
            return 13'($urandom_range(0, 8191));
        return 13'($urandom_range(1, 300));
    endfunction

    // mostly contiguous blocks with queued launches in between; some jumps anywhere
    task automatic random_run(input int count);
        logic [12:0] fr;
        logic [47:0] start;
        repeat (count)
        begin
            if ($urandom_range(99) < 25)
                send_item(clsp_pkg::OP_QUEUE, 4'($urandom_range(0, 15)),
                          48'({$urandom(), $urandom()}), 13'($urandom()),
                          $urandom(), $urandom());
            else
            begin
                fr = rand_frames();
                if ($urandom_range(99) < 8)
                    timeline = 48'({$urandom(), $urandom()});
                start = timeline;
                send_item(clsp_pkg::OP_BLOCK, 4'($urandom()), start, fr, rand_loop(),
                          rand_loop());
                timeline = start + ((fr > 13'd4096) ? 48'd4096 : 48'(fr));
            end
        end
    endtask

    task automatic test_directed();
        write_bar(24'd88200);
        // scene 1 still active from the first check, nothing queued
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd0, 13'd256, 32'd100, 32'd100);
        // launch at a bar inside the block, pending loop shorter than the tail
        send_item(clsp_pkg::OP_QUEUE, 4'd3, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd88100, 13'd200, 32'd0, 32'd50);
        // keep playing across the loop seam
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd88300, 13'd100, 32'd64, 32'd0);
        // block before the activation point
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd100, 13'd16, 32'd7, 32'd0);
        // stop request at the next bar
        send_item(clsp_pkg::OP_QUEUE, 4'hF, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd176300, 13'd200, 32'hFFFF_FFFF, 32'd9);
        // unplayable pending scene
        send_item(clsp_pkg::OP_QUEUE, 4'd7, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd264600, 13'd10, 32'd5, 32'd0);
        // most negative request queues a stop, empty block, oversized block
        send_item(clsp_pkg::OP_QUEUE, 4'd8, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd352800, 13'd0, 32'd5, 32'd5);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd352800, 13'd8191, 32'd5, 32'd5);
        // launch at block start, then the top of the timeline
        send_item(clsp_pkg::OP_QUEUE, 4'd0, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd441000, 13'd4096, 32'd1, 32'd4095);
        send_item(clsp_pkg::OP_QUEUE, 4'd5, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'hFFFF_FFFF_FFFF, 13'd4096, 32'd3,
                  32'hFFFF_FFFF);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'hFFFF_FFFF_F000, 13'd4096, 32'd1000, 32'd0);
        go_idle();
    endtask

    task automatic test_bar_zero_and_max();
        write_bar(24'd0);
        send_item(clsp_pkg::OP_QUEUE, 4'd2, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd0, 13'd4096, 32'd77, 32'd77);
        random_run(40);
        go_idle();
        write_bar(24'hFF_FFFF);
        send_item(clsp_pkg::OP_QUEUE, 4'd4, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'hFF_FF00, 13'd512, 32'd33, 32'd21);
        timeline = 48'h1FF_FE00;
        random_run(40);
        go_idle();
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_bar(24'd100);
        timeline = 48'd0;
        random_run(90);
        go_idle();
        send_idle_pct = 53;
        write_bar(24'd1);
        random_run(80);
        go_idle();
        send_idle_pct = 0;
        recv_stall_pct = 53;
        write_bar(24'd777);
        random_run(80);
        go_idle();
        send_idle_pct = 31;
        recv_stall_pct = 31;
        write_bar(24'($urandom_range(1, 24'hFF_FFFF)));
        random_run(40);
        go_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_bar(24'd50);
        hold_request = 1500;
        random_run(30);
        go_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        hold_off = 1'b0;
        timeline = '0;
        bar_len = clsp_pkg::BAR_RESET;
        active_scene = -1;
        pending_scene = -1;
        stop_queued = 1'b0;
        activation_pos = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of bar_length before any write
        send_item(clsp_pkg::OP_QUEUE, 4'd1, '0, '0, '0, '0);
        send_item(clsp_pkg::OP_BLOCK, 4'd0, 48'd88190, 13'd20, 32'd3, 32'd8);
        go_idle();

        test_directed();
        test_bar_zero_and_max();
        test_idle_phases();
        test_backpressure();

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
